/* hdl/rcpb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpb_pkg
// Shared types, constants and helper functions of the radio packet builder.
// ----------------------------------------------------------------------------
package rcpb_pkg;

    localparam int FRAME_LEN = 15;
    localparam int BODY_LEN  = 10;

    localparam logic [3:0] LAST_INDEX = 4'd14;

    localparam logic [7:0] LEAD_BIND  = 8'hA4;
    localparam logic [7:0] LEAD_DATA  = 8'hA5;
    localparam logic [7:0] DATA_ADDR  = 8'hFA;
    localparam logic [7:0] TAIL_BYTE  = 8'h0A;
    localparam logic [7:0] STICK_TRIM = 8'h7C;

    // Stick offset: value - 1500 + 0x1FF, i.e. value - 989.
    localparam logic [13:0] STICK_BIAS = 14'd989;
    localparam logic [13:0] STICK_MAX  = 14'd1023;

    localparam logic [2:0] CFG_TX_ID        = 3'd0;
    localparam logic [2:0] CFG_FLAGS_FIRST  = 3'd1;
    localparam logic [2:0] CFG_FLAGS_SECOND = 3'd2;
    localparam logic [2:0] CFG_BIND_CHANNEL = 3'd3;
    localparam logic [2:0] CFG_BIND_TICKS   = 3'd4;

    localparam logic [15:0] BIND_TICKS_RESET = 16'd1000;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SEND
    } state_t;

    typedef struct packed {
        logic       accept;
        logic       emit;
        logic [3:0] idx;
    } cmd_t;

    typedef struct packed {
        logic frame;
        logic out_free;
    } status_t;

    // Hop channel k for the low address byte a3.
    function automatic logic [7:0] hop_channel(input logic [7:0] a3, input logic [1:0] k);
        logic [7:0] h1;
        logic [7:0] res;
        h1 = {3'b000, a3[4:0]} + 8'h10;
        unique case (k)
            2'd0: res = 8'h00;
            2'd1: res = h1;
            2'd2: res = h1 + 8'h20;
            default: res = h1 + 8'h40;
        endcase
        return res;
    endfunction

    // Offset and clamp one stick to 10 bits, returned as {high byte, low byte}.
    function automatic logic [15:0] encode_stick(input logic [11:0] raw);
        logic [13:0] diff;
        logic [9:0]  v;
        diff = {2'b00, raw} - STICK_BIAS;
        if ({2'b00, raw} < STICK_BIAS) begin
            v = 10'd0;
        end else if (diff > STICK_MAX) begin
            v = 10'd1023;
        end else begin
            v = diff[9:0];
        end
        return {STICK_TRIM + {6'b000000, v[9:8]}, v[7:0]};
    endfunction

endpackage

/* hdl/rcpb_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpb_ctrl
// Controller: accepts a word, then steps the byte index while the output
// register is free.
// ----------------------------------------------------------------------------
module rcpb_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  rcpb_pkg::status_t status,
    output rcpb_pkg::cmd_t    cmd
);
    import rcpb_pkg::*;

    state_t     state_reg;
    state_t     state_next;
    logic [3:0] idx_reg;
    logic [3:0] idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        in_stall   = 1'b1;
        cmd.accept = 1'b0;
        cmd.emit   = 1'b0;
        cmd.idx    = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_SEND;
                    idx_next   = 4'd0;
                end
            end
            ST_SEND:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    // A tick that sends nothing gives a single word.
                    if (!status.frame || idx_reg == LAST_INDEX)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 4'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> (state_reg == ST_SEND && idx_reg == 4'd0))
        else $error("accept did not start a frame at index zero");

    a_last_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && idx_reg == LAST_INDEX) |=> (state_reg == ST_IDLE))
        else $error("controller did not return to idle after the last byte");

    a_no_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !cmd.emit)
        else $error("emit while idle");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEND) |-> (idx_reg <= LAST_INDEX))
        else $error("byte index beyond frame");

endmodule

/* hdl/rcpb_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpb_datapath
// Datapath: configuration registers, mode and hop state, frame body,
// checksum accumulator and output register.
// ----------------------------------------------------------------------------
module rcpb_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic [2:0]       cfg_index,
    input  logic [31:0]      cfg_data,
    input  rcpb_pkg::cmd_t    cmd,
    output rcpb_pkg::status_t status,
    input  logic             opcode,
    input  logic             sticks_valid,
    input  logic [11:0]      aileron,
    input  logic [11:0]      elevator,
    input  logic [11:0]      throttle,
    input  logic [11:0]      rudder,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       frame_byte,
    output logic [3:0]       byte_index,
    output logic             frame_sent,
    output logic [6:0]       radio_channel,
    output logic             last
);
    import rcpb_pkg::*;

    logic [31:0] tx_id_reg;
    logic [7:0]  flags_first_reg;
    logic [7:0]  flags_second_reg;
    logic [6:0]  bind_channel_reg;
    logic [15:0] bind_ticks_reg;

    logic        binding_reg;
    logic [15:0] bind_remaining_reg;
    logic [1:0]  hop_index_reg;
    logic [7:0]  body_reg [BODY_LEN];

    logic        send_reg;
    logic [7:0]  lead_reg;
    logic [7:0]  second_reg;
    logic [6:0]  chan_reg;
    logic [7:0]  sum_reg;

    logic        out_valid_reg;
    logic [7:0]  frame_byte_reg;
    logic [3:0]  byte_index_reg;
    logic        frame_sent_reg;
    logic [6:0]  radio_channel_reg;
    logic        last_reg;

    logic [7:0]  a0;
    logic [7:0]  a1;
    logic [7:0]  a2;
    logic [7:0]  a3;
    logic [7:0]  a4;
    logic [15:0] remaining_dec;
    logic [15:0] enc_ail;
    logic [15:0] enc_ele;
    logic [15:0] enc_thr;
    logic [15:0] enc_rud;
    logic [7:0]  hop_now;
    logic [3:0]  body_off;
    logic [7:0]  sel_byte;

    assign a0 = tx_id_reg[31:24];
    assign a1 = tx_id_reg[23:16];
    assign a2 = tx_id_reg[15:8];
    assign a3 = tx_id_reg[7:0];
    assign a4 = {a2[7:4], a3[3:0]};

    assign remaining_dec = bind_remaining_reg - 16'd1;
    assign enc_ail = encode_stick(aileron);
    assign enc_ele = encode_stick(elevator);
    assign enc_thr = encode_stick(throttle);
    assign enc_rud = encode_stick(rudder);
    assign hop_now = hop_channel(a3, hop_index_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_id_reg        <= 32'd0;
            flags_first_reg  <= 8'd0;
            flags_second_reg <= 8'd0;
            bind_channel_reg <= 7'd0;
            bind_ticks_reg   <= BIND_TICKS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_TX_ID:        tx_id_reg        <= cfg_data;
                CFG_FLAGS_FIRST:  flags_first_reg  <= cfg_data[7:0];
                CFG_FLAGS_SECOND: flags_second_reg <= cfg_data[7:0];
                CFG_BIND_CHANNEL: bind_channel_reg <= cfg_data[6:0];
                CFG_BIND_TICKS:   bind_ticks_reg   <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Mode, hop and body state change once, at the edge that takes a word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            binding_reg        <= 1'b1;
            bind_remaining_reg <= BIND_TICKS_RESET;
            hop_index_reg      <= 2'd0;
            send_reg           <= 1'b0;
            for (int i = 0; i < BODY_LEN; i++)
            begin
                body_reg[i] <= 8'd0;
            end
        end
        else if (cmd.accept)
        begin
            priority if (opcode)
            begin
                binding_reg        <= 1'b1;
                bind_remaining_reg <= bind_ticks_reg;
                send_reg           <= 1'b0;
            end
            else if (binding_reg)
            begin
                bind_remaining_reg <= remaining_dec;
                if (remaining_dec == 16'd0)
                begin
                    binding_reg <= 1'b0;
                    send_reg    <= 1'b0;
                end
                else
                begin
                    send_reg      <= 1'b1;
                    hop_index_reg <= hop_index_reg + 2'd1;
                    body_reg[0]   <= a1;
                    body_reg[1]   <= a2;
                    body_reg[2]   <= a3;
                    body_reg[3]   <= a4;
                    body_reg[4]   <= hop_channel(a3, 2'd0);
                    body_reg[5]   <= hop_channel(a3, 2'd1);
                    body_reg[6]   <= hop_channel(a3, 2'd2);
                    body_reg[7]   <= hop_channel(a3, 2'd3);
                    body_reg[8]   <= a0;
                    body_reg[9]   <= a1;
                end
            end
            else
            begin
                send_reg      <= 1'b1;
                hop_index_reg <= hop_index_reg + 2'd1;
                if (sticks_valid)
                begin
                    body_reg[0] <= flags_first_reg;
                    body_reg[1] <= flags_second_reg;
                    body_reg[2] <= enc_ail[15:8];
                    body_reg[3] <= enc_ail[7:0];
                    body_reg[4] <= enc_ele[15:8];
                    body_reg[5] <= enc_ele[7:0];
                    body_reg[6] <= enc_thr[15:8];
                    body_reg[7] <= enc_thr[7:0];
                    body_reg[8] <= enc_rud[15:8];
                    body_reg[9] <= enc_rud[7:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            if (binding_reg)
            begin
                lead_reg   <= LEAD_BIND;
                second_reg <= a0;
                chan_reg   <= bind_channel_reg;
            end
            else
            begin
                lead_reg   <= LEAD_DATA;
                second_reg <= DATA_ADDR;
                chan_reg   <= hop_now[6:0];
            end
        end
    end

    assign body_off = cmd.idx - 4'd2;

    always_comb
    begin
        unique case (cmd.idx)
            4'd0:    sel_byte = lead_reg;
            4'd1:    sel_byte = second_reg;
            4'd12:   sel_byte = a2;
            4'd13:   sel_byte = TAIL_BYTE;
            4'd14:   sel_byte = sum_reg;
            4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11:
                     sel_byte = body_reg[body_off];
            default: sel_byte = 8'd0;
        endcase
    end

    // The checksum builds up as the bytes go out, ready for the last one.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sum_reg <= 8'd0;
        end
        else if (cmd.emit)
        begin
            sum_reg <= sum_reg + sel_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            if (send_reg)
            begin
                frame_byte_reg    <= sel_byte;
                byte_index_reg    <= cmd.idx;
                frame_sent_reg    <= 1'b1;
                radio_channel_reg <= chan_reg;
                last_reg          <= (cmd.idx == LAST_INDEX);
            end
            else
            begin
                frame_byte_reg    <= 8'd0;
                byte_index_reg    <= 4'd0;
                frame_sent_reg    <= 1'b0;
                radio_channel_reg <= 7'd0;
                last_reg          <= 1'b1;
            end
        end
    end

    assign status.frame    = send_reg;
    assign status.out_free = !out_valid_reg || !out_stall;

    assign out_valid     = out_valid_reg;
    assign frame_byte    = frame_byte_reg;
    assign byte_index    = byte_index_reg;
    assign frame_sent    = frame_sent_reg;
    assign radio_channel = radio_channel_reg;
    assign last          = last_reg;

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !frame_sent_reg) |-> (last_reg && byte_index_reg == 4'd0))
        else $error("empty result is not a single last word");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !cmd.emit)
        else $error("output register overwritten while stalled");

    a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && frame_sent_reg) |-> (last_reg == (byte_index_reg == LAST_INDEX)))
        else $error("last flag does not match the final frame byte");

endmodule

/* hdl/rc_radio_packet_builder_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_radio_packet_builder_core
// Builds a 15-byte bind or data frame per tick, or a single empty word, and streams
// it out byte by byte with its radio channel.
// ----------------------------------------------------------------------------
// The controller steps the byte index, and each byte word is registered into the output register.
// A frame tick streams its 15 byte words, one per cycle while the output register is
// free; a tick that sends nothing streams a single word. Output stalls hold the
// stream; the next word is taken only when idle.
// Reset (rst_n, asynchronous, active low) enters bind mode with 1000 ticks,
// hop index 0, a zero frame body and the register reset values.
module rc_radio_packet_builder_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic        sticks_valid,
    input  logic [11:0] aileron,
    input  logic [11:0] elevator,
    input  logic [11:0] throttle,
    input  logic [11:0] rudder,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  frame_byte,
    output logic [3:0]  byte_index,
    output logic        frame_sent,
    output logic [6:0]  radio_channel,
    output logic        last
);
    import rcpb_pkg::*;

    cmd_t    cmd;
    status_t status;

    rcpb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    rcpb_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .status        (status),
        .opcode        (opcode),
        .sticks_valid  (sticks_valid),
        .aileron       (aileron),
        .elevator      (elevator),
        .throttle      (throttle),
        .rudder        (rudder),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .frame_byte    (frame_byte),
        .byte_index    (byte_index),
        .frame_sent    (frame_sent),
        .radio_channel (radio_channel),
        .last          (last)
    );

endmodule

/* tb/rc_radio_packet_builder_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_radio_packet_builder_core_tb
// Drives tick and restart words into the frame builder, mirrors its bind and
// data frame generation, stick encoding and hop sequence in a local model,
// and checks every streamed frame word against that model.
// ----------------------------------------------------------------------------
module rc_radio_packet_builder_core_tb;

    import rcpb_pkg::*;

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    localparam int         WORDS_PER_FRAME = 15;
    localparam logic [7:0] BIND_LEAD       = 8'hA4;
    localparam logic [7:0] DATA_LEAD       = 8'hA5;
    localparam logic [7:0] DATA_SYNC       = 8'hFA;
    localparam logic [7:0] FRAME_TAIL      = 8'h0A;
    localparam logic [7:0] CENTRE_TRIM     = 8'h7C;
    localparam int         STICK_CENTRE    = 1500;
    localparam int         STICK_HALF      = 'h1FF;
    localparam int         STICK_TOP       = 1023;

    localparam int IDLE_PERCENT  = 19;
    localparam int HOLD_CYCLES   = 80;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_WORDS  = 90;
    localparam int TIMEOUT_NS    = 1000000;

    typedef struct packed {
        logic [7:0] data;
        logic [3:0] pos;
        logic       sent;
        logic [6:0] chan;
        logic       fin;
    } frame_word_t;

    localparam frame_word_t NOTHING_WORD = '{8'h00, 4'h0, 1'b0, 7'h00, 1'b1};

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_WORD,
        ROW_NOTHING
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [2:0]  reg_idx;
        logic [31:0] reg_val;
        logic        op;
        logic        sv;
        logic [11:0] ail;
        logic [11:0] ele;
        logic [11:0] thr;
        logic [11:0] rud;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        opcode;
    logic        sticks_valid;
    logic [11:0] aileron;
    logic [11:0] elevator;
    logic [11:0] throttle;
    logic [11:0] rudder;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  frame_byte;
    logic [3:0]  byte_index;
    logic        frame_sent;
    logic [6:0]  radio_channel;
    logic        last;

    // Register mirror and frame builder state of the local model.
    logic [31:0] m_tx_id;
    logic [7:0]  m_flags_first;
    logic [7:0]  m_flags_second;
    logic [6:0]  m_bind_chan;
    logic [15:0] m_bind_ticks;
    logic        bind_mode;
    logic [15:0] bind_left;
    logic [1:0]  hop;
    logic [7:0]  body [10];

    frame_word_t frame_words [WORDS_PER_FRAME];
    int          frame_len;
    frame_word_t expected_words [$];

    int fail_count   = 0;
    bit calm         = 1'b0;
    bit hold_pending = 1'b0;

    dir_row_t dir_rows [0:32] = '{
        '{ROW_CFG,     CFG_TX_ID,        'hFFFF_FFFF, OP_TICK,    0, 0, 0, 0, 0},
        '{ROW_CFG,     CFG_FLAGS_FIRST,  'hFF,        OP_TICK,    0, 0, 0, 0, 0},
        '{ROW_CFG,     CFG_FLAGS_SECOND, 'h00,        OP_TICK,    0, 0, 0, 0, 0},
        '{ROW_CFG,     CFG_BIND_CHANNEL, 'h7F,        OP_TICK,    0, 0, 0, 0, 0},
        '{ROW_CFG,     CFG_BIND_TICKS,   3,           OP_TICK,    0, 0, 0, 0, 0},
        '{ROW_WORD,    CFG_TX_ID,        0,           OP_TICK,    0, 0, 0, 0, 0},
        '{ROW_NOTHING, CFG_TX_ID,        0,           OP_RESTART, 0, 0, 0, 0, 0},
        '{ROW_WORD,    CFG_TX_ID,        0,           OP_TICK,    0, 0, 0, 0, 0},
        '{ROW_WORD,    CFG_TX_ID,        0,           OP_TICK,    1, 123, 2345, 4000, 7},
        '{ROW_NOTHING, CFG_TX_ID,        0,           OP_TICK,    0, 0, 0, 0, 0},
        '{ROW_WORD,    CFG_TX_ID,        0,           OP_TICK,    0, 0, 0, 0, 0},
        '{ROW_WORD,    CFG_TX_ID,        0,           OP_TICK,    1, 0, 0, 0, 0},
        '{ROW_WORD,    CFG_TX_ID,        0,           OP_TICK,    1, 4095, 4095, 4095, 4095},
        '{ROW_WORD,    CFG_TX_ID,        0,           OP_TICK,    1, 1500, 1500, 1500, 1500},
        '{ROW_WORD,    CFG_TX_ID,        0,           OP_TICK,    1, 988, 989, 2012, 2013},
        '{ROW_WORD,    CFG_TX_ID,        0,           OP_TICK,    0, 0, 0, 0, 0},
        '{ROW_CFG,     CFG_TX_ID,        0,           OP_TICK,    0, 0, 0, 0, 0},
        '{ROW_CFG,     CFG_FLAGS_FIRST,  'h00,        OP_TICK,    0, 0, 0, 0, 0},
        '{ROW_CFG,     CFG_FLAGS_SECOND, 'hFF,        OP_TICK,    0, 0, 0, 0, 0},
        '{ROW_CFG,     CFG_BIND_CHANNEL, 0,           OP_TICK,    0, 0, 0, 0, 0},
        '{ROW_CFG,     CFG_BIND_TICKS,   1,           OP_TICK,    0, 0, 0, 0, 0},
        '{ROW_WORD,    CFG_TX_ID,        0,           OP_TICK,    1, 1000, 2000, 1500, 1234},
        '{ROW_NOTHING, CFG_TX_ID,        0,           OP_RESTART, 0, 0, 0, 0, 0},
        '{ROW_NOTHING, CFG_TX_ID,        0,           OP_TICK,    0, 0, 0, 0, 0},
        '{ROW_WORD,    CFG_TX_ID,        0,           OP_TICK,    0, 0, 0, 0, 0},
        '{ROW_CFG,     CFG_BIND_TICKS,   0,           OP_TICK,    0, 0, 0, 0, 0},
        '{ROW_CFG,     CFG_BIND_CHANNEL, 'h55,        OP_TICK,    0, 0, 0, 0, 0},
        '{ROW_NOTHING, CFG_TX_ID,        0,           OP_RESTART, 0, 0, 0, 0, 0},
        '{ROW_WORD,    CFG_TX_ID,        0,           OP_TICK,    0, 0, 0, 0, 0},
        '{ROW_WORD,    CFG_TX_ID,        0,           OP_TICK,    1, 1, 2, 3, 4},
        '{ROW_CFG,     CFG_BIND_TICKS,   'hFFFF,      OP_TICK,    0, 0, 0, 0, 0},
        '{ROW_NOTHING, CFG_TX_ID,        0,           OP_RESTART, 0, 0, 0, 0, 0},
        '{ROW_WORD,    CFG_TX_ID,        0,           OP_TICK,    0, 0, 0, 0, 0}
    };

    rc_radio_packet_builder_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .sticks_valid  (sticks_valid),
        .aileron       (aileron),
        .elevator      (elevator),
        .throttle      (throttle),
        .rudder        (rudder),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .frame_byte    (frame_byte),
        .byte_index    (byte_index),
        .frame_sent    (frame_sent),
        .radio_channel (radio_channel),
        .last          (last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

    function automatic logic [6:0] hop_chan(input logic [7:0] low_addr, input logic [1:0] k);
        logic [6:0] base;
        logic [6:0] res;
        base = {2'b00, low_addr[4:0]} + 7'h10;
        case (k)
            2'd0: res = 7'h00;
            2'd1: res = base;
            2'd2: res = base + 7'h20;
            default: res = base + 7'h40;
        endcase
        return res;
    endfunction

    // Offset around the centre, clamp to ten bits, add the centre trim to the high byte.
    function automatic logic [15:0] stick_code(input logic [11:0] raw);
        int v;
        logic [7:0] hi;
        v = int'(raw) - STICK_CENTRE + STICK_HALF;
        if (v < 0)
        begin
            v = 0;
        end
        if (v > STICK_TOP)
        begin
            v = STICK_TOP;
        end
        hi = 8'(v >> 8) + CENTRE_TRIM;
        return {hi, 8'(v)};
    endfunction

    task automatic predict_frame(input logic op, input logic sv, input logic [11:0] ail,
                                 input logic [11:0] ele, input logic [11:0] thr,
                                 input logic [11:0] rud);
        logic [7:0] fr [WORDS_PER_FRAME];
        logic [7:0] a0;
        logic [7:0] a1;
        logic [7:0] a2;
        logic [7:0] a3;
        logic [7:0] sum;
        logic [6:0] ch;
        bit         nothing;
        a0 = m_tx_id[31:24];
        a1 = m_tx_id[23:16];
        a2 = m_tx_id[15:8];
        a3 = m_tx_id[7:0];
        nothing = 1'b0;
        ch = 7'h00;
        fr[0] = 8'h00;
        fr[1] = 8'h00;
        if (op == OP_RESTART)
        begin
            bind_mode = 1'b1;
            bind_left = m_bind_ticks;
            nothing = 1'b1;
        end
        else if (bind_mode)
        begin
            bind_left = bind_left - 16'd1;
            if (bind_left == 16'd0)
            begin
                bind_mode = 1'b0;
                nothing = 1'b1;
            end
            else
            begin
                fr[0] = BIND_LEAD;
                fr[1] = a0;
                body[0] = a1;
                body[1] = a2;
                body[2] = a3;
                body[3] = {a2[7:4], a3[3:0]};
                for (int k = 0; k < 4; k++)
                begin
                    body[4 + k] = {1'b0, hop_chan(a3, 2'(k))};
                end
                body[8] = a0;
                body[9] = a1;
                ch = m_bind_chan;
            end
        end
        else
        begin
            if (sv)
            begin
                body[0] = m_flags_first;
                body[1] = m_flags_second;
                {body[2], body[3]} = stick_code(ail);
                {body[4], body[5]} = stick_code(ele);
                {body[6], body[7]} = stick_code(thr);
                {body[8], body[9]} = stick_code(rud);
            end
            fr[0] = DATA_LEAD;
            fr[1] = DATA_SYNC;
            ch = hop_chan(a3, hop);
        end

        if (nothing)
        begin
            frame_words[0] = NOTHING_WORD;
            frame_len = 1;
        end
        else
        begin
            for (int i = 0; i < 10; i++)
            begin
                fr[2 + i] = body[i];
            end
            fr[12] = a2;
            fr[13] = FRAME_TAIL;
            sum = 8'h00;
            for (int i = 0; i < WORDS_PER_FRAME - 1; i++)
            begin
                sum = sum + fr[i];
            end
            fr[14] = sum;
            hop = hop + 2'd1;
            for (int i = 0; i < WORDS_PER_FRAME; i++)
            begin
                frame_words[i] = '{fr[i], 4'(i), 1'b1, ch, i == WORDS_PER_FRAME - 1};
            end
            frame_len = WORDS_PER_FRAME;
        end
    endtask

    // Offers one input word at the falling edge and waits for it to be taken.
    task automatic send_word(input logic op, input logic sv, input logic [11:0] ail,
                             input logic [11:0] ele, input logic [11:0] thr,
                             input logic [11:0] rud, input bit typed_nothing);
        cfg_write <= 1'b0;
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        sticks_valid <= sv;
        aileron      <= ail;
        elevator     <= ele;
        throttle     <= thr;
        rudder       <= rud;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        predict_frame(op, sv, ail, ele, thr, rud);
        if (typed_nothing)
        begin
            expected_words.push_back(NOTHING_WORD);
        end
        else
        begin
            for (int i = 0; i < frame_len; i++)
            begin
                expected_words.push_back(frame_words[i]);
            end
        end
        @(negedge clk);
    endtask

    task automatic drain_block();
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_TX_ID:        m_tx_id = val;
            CFG_FLAGS_FIRST:  m_flags_first = val[7:0];
            CFG_FLAGS_SECOND: m_flags_second = val[7:0];
            CFG_BIND_CHANNEL: m_bind_chan = val[6:0];
            CFG_BIND_TICKS:   m_bind_ticks = val[15:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    function automatic logic [11:0] pick_stick();
        int r;
        logic [11:0] v;
        r = $urandom_range(0, 99);
        if (r < 65)
        begin
            v = 12'($urandom_range(900, 2100));
        end
        else if (r < 85)
        begin
            v = 12'($urandom_range(0, 4095));
        end
        else
        begin
            case ($urandom_range(0, 5))
                0: v = 12'd0;
                1: v = 12'd4095;
                2: v = 12'd988;
                3: v = 12'd989;
                4: v = 12'd2012;
                default: v = 12'd2013;
            endcase
        end
        return v;
    endfunction

    // Receiver side: random stalls, or one long hold-off when asked for.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                out_stall <= 1'b1;
                for (int n = 1; n < HOLD_CYCLES; n++)
                begin
                    @(negedge clk);
                end
            end
            else
            begin
                out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
            end
        end
    end

    always @(posedge clk)
    begin
        frame_word_t got;
        frame_word_t want;
        if (out_valid && !out_stall)
        begin
            got = '{frame_byte, byte_index, frame_sent, radio_channel, last};
            if (expected_words.size() == 0)
            begin
                if (fail_count < 10)
                begin
                    $display("unexpected word: byte %02h index %0d sent %0b chan %0d last %0b",
                             got.data, got.pos, got.sent, got.chan, got.fin);
                end
                fail_count++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (got.data !== want.data || got.pos !== want.pos || got.sent !== want.sent
                    || got.chan !== want.chan || got.fin !== want.fin)
                begin
                    if (fail_count < 10)
                    begin
                        $display("mismatch: expected byte %02h index %0d sent %0b chan %0d last %0b",
                                 want.data, want.pos, want.sent, want.chan, want.fin);
                        $display("          got      byte %02h index %0d sent %0b chan %0d last %0b",
                                 got.data, got.pos, got.sent, got.chan, got.fin);
                    end
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        dir_row_t row;
        bit       words_since_cfg;
        int       rand_words;
        int       n;
        logic     op;
        logic     sv;

        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = CFG_TX_ID;
        cfg_data     = 32'h0;
        in_valid     = 1'b0;
        opcode       = OP_TICK;
        sticks_valid = 1'b0;
        aileron      = 12'd0;
        elevator     = 12'd0;
        throttle     = 12'd0;
        rudder       = 12'd0;

        m_tx_id        = 32'h0;
        m_flags_first  = 8'h00;
        m_flags_second = 8'h00;
        m_bind_chan    = 7'h00;
        m_bind_ticks   = BIND_TICKS_RESET;
        bind_mode      = 1'b1;
        bind_left      = BIND_TICKS_RESET;
        hop            = 2'd0;
        for (int i = 0; i < 10; i++)
        begin
            body[i] = 8'h00;
        end

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        words_since_cfg = 1'b0;
        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.kind == ROW_CFG)
            begin
                if (words_since_cfg)
                begin
                    drain_block();
                end
                words_since_cfg = 1'b0;
                write_reg(row.reg_idx, row.reg_val);
            end
            else
            begin
                send_word(row.op, row.sv, row.ail, row.ele, row.thr, row.rud,
                          row.kind == ROW_NOTHING);
                words_since_cfg = 1'b1;
            end
        end

        // Random phases: fresh settings, a restart, then mostly data ticks.
        rand_words = 0;
        for (int phase = 0; rand_words < RANDOM_WORDS; phase++)
        begin
            drain_block();
            calm = (phase == 2);
            write_reg(CFG_TX_ID, $urandom);
            write_reg(CFG_FLAGS_FIRST, 32'($urandom_range(0, 255)));
            write_reg(CFG_FLAGS_SECOND, 32'($urandom_range(0, 255)));
            write_reg(CFG_BIND_CHANNEL, 32'($urandom_range(0, 127)));
            write_reg(CFG_BIND_TICKS, 32'($urandom_range(1, 4)));
            n = $urandom_range(14, 24);
            for (int k = 0; k < n; k++)
            begin
                if (phase == 1 && k == 2)
                begin
                    hold_pending = 1'b1;
                end
                op = (k == 0 || $urandom_range(0, 24) == 0) ? OP_RESTART : OP_TICK;
                sv = ($urandom_range(0, 99) < 85);
                send_word(op, sv, pick_stick(), pick_stick(), pick_stick(), pick_stick(),
                          1'b0);
            end
            rand_words += n;
        end
        calm = 1'b0;

        in_valid <= 1'b0;
        while (expected_words.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (40) @(negedge clk);

        if (fail_count == 0 && expected_words.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/rcpb_pkg.sv
hdl/rcpb_ctrl.sv
hdl/rcpb_datapath.sv
hdl/rc_radio_packet_builder_core.sv
tb/rc_radio_packet_builder_core_tb.sv
